### src/binary_erosion_square_window_unit_defines.svh
// Assertion macros shared by the erosion unit checker.
// No dependencies.
`ifndef BINARY_EROSION_SQUARE_WINDOW_UNIT_DEFINES_SVH
`define BINARY_EROSION_SQUARE_WINDOW_UNIT_DEFINES_SVH
`define BESW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define BESW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

### src/besw_pkg.sv
// Package for the binary erosion unit: field widths, register indexes, types.
// No dependencies.
`default_nettype none
package besw_pkg;
    localparam int unsigned MaxWidth  = 1024;
    localparam int unsigned MaxHeight = 1024;
    localparam int unsigned MaxKernel = 8;

    localparam int unsigned CfgAw = 4;
    localparam logic [CfgAw-1:0] AddrWidth  = 4'h0;
    localparam logic [CfgAw-1:0] AddrHeight = 4'h4;
    localparam logic [CfgAw-1:0] AddrKernel = 4'h8;
    localparam logic [7:0] FullValue = 8'd255;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] eroded_value;
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic       frame_last;
    } t_out_item;
endpackage
`default_nettype wire

### src/besw_if.sv
// Valid/ready channel interface carrying a packed payload.
// No dependencies.
`default_nettype none
interface besw_if #(
    parameter int unsigned W = 8
) (
    input wire logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/besw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module besw_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/binary_erosion_square_window_unit.sv
// Flow: an accepted item passes WRITE and CHECK; if it releases a result, READ sweeps the N
// window pixels inside the image (up to 225), then WAIT and EMIT; kernel 0 skips READ and WAIT.
// Throughput: one item at a time; an item without a result returns to IDLE after CHECK,
// and EMIT holds while an earlier result still waits on the output.
// Reset: synchronous active low; registers return to 640x480, kernel 1, frame at start.
// Depends on besw_pkg, besw_if, besw_ram.
`default_nettype none
module binary_erosion_square_window_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    besw_if.sink                       i_in,
    besw_if.source                     o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [besw_pkg::CfgAw-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import besw_pkg::*;

    localparam int unsigned Slots = 2 * MaxKernel;
    localparam int unsigned SW    = $clog2(Slots);
    localparam int unsigned CW    = $clog2(MaxWidth);
    localparam int unsigned RW    = $clog2(MaxHeight);
    localparam int unsigned Depth = Slots * MaxWidth;
    localparam int unsigned AW    = $clog2(Depth);
    localparam int unsigned LW    = CW + 1;
    localparam int unsigned HW    = RW + 1;
    localparam int unsigned KW    = $clog2(MaxKernel + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_CHECK = 6'b000100,
        S_READ  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [10:0] r_width, r_height;
    logic [3:0]  r_kernel;
    logic [RW-1:0] r_in_row, r_out_row;
    logic [CW-1:0] r_in_col, r_out_col;
    logic r_frame_rx;
    logic [7:0] r_pix;
    logic r_func;
    logic [RW-1:0] r_rd_row, r_r1;
    logic        r_pass;
    logic [CW-1:0] r_c0;
    t_out_item   r_out;
    logic        r_out_valid;

    // effective sizes
    logic [LW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [KW-1:0] k_eff;
    logic [KW-1:0] reach;
    always_comb begin
        if (r_width == 11'd0) w_eff = LW'(1);
        else if (32'(r_width) > MaxWidth) w_eff = LW'(MaxWidth);
        else w_eff = LW'(r_width);
        if (r_height == 11'd0) h_eff = HW'(1);
        else if (32'(r_height) > MaxHeight) h_eff = HW'(MaxHeight);
        else h_eff = HW'(r_height);
        k_eff = (32'(r_kernel) > MaxKernel) ? KW'(MaxKernel) : KW'(r_kernel);
        reach = (k_eff != '0) ? k_eff - KW'(1) : '0;
    end

    // config port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr)
            AddrWidth:  prdata = 32'(r_width);
            AddrHeight: prdata = 32'(r_height);
            AddrKernel: prdata = 32'(r_kernel);
            default:    prdata = '0;
        endcase
    end

    // window bounds for the current output
    logic [HW:0] need_r_s;
    logic [LW:0] need_c_s;
    logic [RW-1:0] need_r, r0, r1;
    logic [CW-1:0] need_c, c0, c1;
    logic ready_out, last;
    always_comb begin
        need_r_s = (HW+1)'(r_out_row) + (HW+1)'(reach);
        need_c_s = (LW+1)'(r_out_col) + (LW+1)'(reach);
        need_r = (need_r_s < (HW+1)'(h_eff)) ? RW'(need_r_s) : RW'(h_eff - HW'(1));
        need_c = (need_c_s < (LW+1)'(w_eff)) ? CW'(need_c_s) : CW'(w_eff - LW'(1));
        r1 = need_r;
        c1 = need_c;
        r0 = (r_out_row > RW'(reach)) ? r_out_row - RW'(reach) : '0;
        c0 = (r_out_col > CW'(reach)) ? r_out_col - CW'(reach) : '0;
        ready_out = r_frame_rx || (r_in_row > need_r) ||
                    (r_in_row == need_r && r_in_col > need_c);
        last = (HW'(r_out_row) == h_eff - HW'(1)) && (LW'(r_out_col) == w_eff - LW'(1));
    end

    // store: one bit per (row slot, column); the window is swept one bit per cycle,
    // columns first inside each row
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [0:0]    rdata;
    logic [CW-1:0] r_rd_col;

    besw_ram #(.WIDTH(1), .DEPTH(Depth)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(r_pix != 8'd0),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign we    = (r_state == S_WRITE) && !r_func && !r_frame_rx;
    assign waddr = {SW'(r_in_row % RW'(Slots)), r_in_col};
    assign raddr = {SW'(r_rd_row % RW'(Slots)), r_rd_col};

    logic [CW-1:0] r_c1;
    logic          r_rd_pend;

    // hold the finished result until the output register is free
    logic emit_fire;
    assign emit_fire = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= 11'd640;
            r_height    <= 11'd480;
            r_kernel    <= 4'd1;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_frame_rx  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_fire) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            if (cfg_wr && (paddr == AddrWidth || paddr == AddrHeight ||
                           paddr == AddrKernel)) begin
                if (paddr == AddrWidth)  r_width  <= pwdata[10:0];
                if (paddr == AddrHeight) r_height <= pwdata[10:0];
                if (paddr == AddrKernel) r_kernel <= pwdata[3:0];
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_frame_rx <= 1'b0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_in.valid && i_in.ready) begin
                            r_func <= i_in.data[8];
                            r_pix  <= i_in.data[7:0];
                        end
                    end
                    S_WRITE: begin
                        if (!r_func && !r_frame_rx) begin
                            if (LW'(r_in_col) + LW'(1) >= w_eff) begin
                                r_in_col <= '0;
                                if (HW'(r_in_row) + HW'(1) >= h_eff) begin
                                    r_in_row   <= '0;
                                    r_frame_rx <= 1'b1;
                                end else begin
                                    r_in_row <= r_in_row + RW'(1);
                                end
                            end else begin
                                r_in_col <= r_in_col + CW'(1);
                            end
                        end
                    end
                    S_CHECK: begin
                        r_rd_row  <= r0;
                        r_r1      <= r1;
                        r_rd_col  <= c0;
                        r_c0      <= c0;
                        r_c1      <= c1;
                        r_pass    <= 1'b1;
                        r_rd_pend <= 1'b0;
                    end
                    S_READ: begin
                        // issue one bit read per cycle, accumulate the previous one
                        if (r_rd_pend && !rdata[0]) r_pass <= 1'b0;
                        r_rd_pend <= 1'b1;
                        if (r_rd_col == r_c1) begin
                            r_rd_col <= r_c0;
                            r_rd_row <= r_rd_row + RW'(1);
                        end else begin
                            r_rd_col <= r_rd_col + CW'(1);
                        end
                    end
                    S_WAIT: begin
                        if (!rdata[0]) r_pass <= 1'b0;
                    end
                    S_EMIT: begin
                        if (emit_fire) begin
                            r_out.eroded_value <= (k_eff == '0 || r_pass) ? FullValue : 8'd0;
                            r_out.out_row      <= 10'(r_out_row);
                            r_out.out_col      <= 10'(r_out_col);
                            r_out.frame_last   <= last;
                            if (last) begin
                                r_out_row  <= '0;
                                r_out_col  <= '0;
                                r_frame_rx <= 1'b0;
                            end else if (LW'(r_out_col) + LW'(1) >= w_eff) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + RW'(1);
                            end else begin
                                r_out_col <= r_out_col + CW'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid && i_in.ready) n_state = S_WRITE;
            S_WRITE: n_state = S_CHECK;
            S_CHECK: n_state = !ready_out ? S_IDLE : (k_eff == '0) ? S_EMIT : S_READ;
            S_READ:  if ((r_rd_row == r_r1) && (r_rd_col == r_c1)) n_state = S_WAIT;
            S_WAIT:  n_state = S_EMIT;
            S_EMIT:  if (emit_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    logic unused;
    assign unused = ^pwdata[31:11];
endmodule
`default_nettype wire

### src/besw_checker.sv
// Port-level checker for the erosion unit, bound to the top level.
// Depends on the assertion macros header.
`default_nettype none
`include "binary_erosion_square_window_unit_defines.svh"
module besw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [28:0] out_data,
    input wire logic        pready
);
    `BESW_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `BESW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `BESW_ASSERT_IMPL(a_value, i_clk, i_rst_n, out_valid, out_data[28:21] == 8'd0 || out_data[28:21] == 8'd255)
    `BESW_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
endmodule
bind binary_erosion_square_window_unit besw_checker u_besw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_in.valid),
    .in_ready (i_in.ready),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .out_data (o_out.data),
    .pready   (pready)
);
`default_nettype wire
